### rtl/sckl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sckl_pkg;

  // Input item kinds as they arrive on the input channel.
  localparam logic [2:0] KIND_TICK      = 3'd0;
  localparam logic [2:0] KIND_PASS_LED  = 3'd1;
  localparam logic [2:0] KIND_FAIL_LED  = 3'd2;
  localparam logic [2:0] KIND_TEST_LED  = 3'd3;
  localparam logic [2:0] KIND_BUZZ_TIME = 3'd4;
  localparam logic [2:0] KIND_BUZZ_SET  = 3'd5;
  localparam logic [2:0] KIND_SCAN      = 3'd6;

  // Bit positions in the upper chain byte.
  localparam int unsigned BIT_PASS = 0;
  localparam int unsigned BIT_FAIL = 1;
  localparam int unsigned BIT_BUZZ = 2;

  // Keypad geometry.
  localparam int unsigned SCAN_COLUMNS = 8;
  localparam int unsigned COL_W        = 4;
  localparam int unsigned ROW_W        = 4;
  localparam int unsigned KEY_W        = 32;

  // Default depths of the internal queues.
  localparam int unsigned OP_QUEUE_DEPTH  = 2;
  localparam int unsigned OUT_QUEUE_DEPTH = 2;

  // Operations handed from the front to the back.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_PASS_LED,
    OP_FAIL_LED,
    OP_TEST_LED,
    OP_BUZZ_TIME,
    OP_BUZZ_SET,
    OP_SCAN_BEGIN,
    OP_SCAN_SAMPLE
  } op_code_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        level;
    logic [15:0] duration;
    logic [3:0]  row_sample;
    logic        scan_begin;
  } in_item_t;

  typedef struct packed {
    logic [15:0] frame;
    logic        frame_sent;
    logic        test_led;
    logic [31:0] key_value;
    logic        key_valid;
    logic [15:0] buzzer_left;
  } out_item_t;

  // Classified operation; rows are already inverted to active high.
  typedef struct packed {
    op_code_t         code;
    logic             level;
    logic [15:0]      duration;
    logic [ROW_W-1:0] rows;
  } op_t;

endpackage

`default_nettype wire

### rtl/sckl_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module sckl_fifo #(
  parameter int unsigned DEPTH = sckl_pkg::OP_QUEUE_DEPTH,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      rdata
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset; entries are read only after being written.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fifo fill count beyond depth");

  a_push_only_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("fifo count did not grow on a lone push");

  a_ptr_align: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CW'(DEPTH)) |-> (rd_ptr_r == wr_ptr_r))
    else $error("fifo pointers disagree with fill count");

endmodule

`default_nettype wire

### rtl/sckl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sckl_front (
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire sckl_pkg::in_item_t in_item,
  output logic                    op_push,
  input  wire logic               op_full,
  output sckl_pkg::op_t           op
);

  // Accept whenever the operation queue has room.
  assign in_full = op_full;
  assign op_push = in_push && !op_full;

  // Classify the item into one operation for the back end.
  always_comb begin
    op.level    = in_item.level;
    op.duration = in_item.duration;
    op.rows     = ~in_item.row_sample;
    unique case (in_item.kind)
      sckl_pkg::KIND_TICK:      op.code = sckl_pkg::OP_TICK;
      sckl_pkg::KIND_PASS_LED:  op.code = sckl_pkg::OP_PASS_LED;
      sckl_pkg::KIND_FAIL_LED:  op.code = sckl_pkg::OP_FAIL_LED;
      sckl_pkg::KIND_TEST_LED:  op.code = sckl_pkg::OP_TEST_LED;
      sckl_pkg::KIND_BUZZ_TIME: op.code = sckl_pkg::OP_BUZZ_TIME;
      sckl_pkg::KIND_BUZZ_SET:  op.code = sckl_pkg::OP_BUZZ_SET;
      sckl_pkg::KIND_SCAN: begin
        op.code = in_item.scan_begin ? sckl_pkg::OP_SCAN_BEGIN : sckl_pkg::OP_SCAN_SAMPLE;
      end
      default:                  op.code = sckl_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/sckl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sckl_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           op_empty,
  input  wire sckl_pkg::op_t  op,
  output logic                op_pop,
  output logic                res_push,
  input  wire logic           res_full,
  output sckl_pkg::out_item_t res
);

  logic [7:0]                    chain1_r, chain1_nxt;
  logic [7:0]                    chain0_r, chain0_nxt;
  logic [15:0]                   buzz_cnt_r, buzz_cnt_nxt;
  logic [sckl_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [sckl_pkg::KEY_W-1:0]    acc_r, acc_nxt;
  logic                          test_r, test_nxt;
  logic [sckl_pkg::KEY_W-1:0]    acc_shift;
  logic [sckl_pkg::COL_W-1:0]    col_inc;
  logic                          sent, valid;
  logic [sckl_pkg::KEY_W-1:0]    key;

  // One operation per beat when the result queue has room.
  assign op_pop   = !op_empty && !res_full;
  assign res_push = op_pop;

  assign acc_shift = {acc_r[sckl_pkg::KEY_W-sckl_pkg::ROW_W-1:0], op.rows};
  assign col_inc   = col_r + 1'b1;

  // Execute the operation against the latch image and scan state.
  always_comb begin
    chain1_nxt   = chain1_r;
    chain0_nxt   = chain0_r;
    buzz_cnt_nxt = buzz_cnt_r;
    col_nxt      = col_r;
    acc_nxt      = acc_r;
    test_nxt     = test_r;
    sent         = 1'b0;
    valid        = 1'b0;
    key          = '0;
    unique case (op.code)
      sckl_pkg::OP_TICK: begin
        if (buzz_cnt_r != '0) begin
          buzz_cnt_nxt = buzz_cnt_r - 1'b1;
          if (buzz_cnt_r == 16'd1) begin
            chain1_nxt[sckl_pkg::BIT_BUZZ] = 1'b0;
            sent = 1'b1;
          end
        end
      end
      sckl_pkg::OP_PASS_LED: begin
        chain1_nxt[sckl_pkg::BIT_PASS] = op.level;
        sent = 1'b1;
      end
      sckl_pkg::OP_FAIL_LED: begin
        chain1_nxt[sckl_pkg::BIT_FAIL] = op.level;
        sent = 1'b1;
      end
      sckl_pkg::OP_TEST_LED: begin
        test_nxt = op.level;
      end
      sckl_pkg::OP_BUZZ_TIME: begin
        buzz_cnt_nxt = op.duration;
        chain1_nxt[sckl_pkg::BIT_BUZZ] = 1'b1;
        sent = 1'b1;
      end
      sckl_pkg::OP_BUZZ_SET: begin
        chain1_nxt[sckl_pkg::BIT_BUZZ] = op.level;
        sent = 1'b1;
      end
      sckl_pkg::OP_SCAN_BEGIN: begin
        col_nxt    = '0;
        acc_nxt    = '0;
        chain0_nxt = 8'hFE;
        sent       = 1'b1;
      end
      sckl_pkg::OP_SCAN_SAMPLE: begin
        if (col_inc >= sckl_pkg::COL_W'(sckl_pkg::SCAN_COLUMNS)) begin
          // Last column: report the key word, keep the column driven.
          key     = acc_shift;
          valid   = 1'b1;
          acc_nxt = '0;
          col_nxt = '0;
        end else begin
          acc_nxt    = acc_shift;
          col_nxt    = col_inc;
          chain0_nxt = ~(8'd1 << col_inc[2:0]);
          sent       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result beat reflects the state after the operation.
  always_comb begin
    res.frame       = {chain1_nxt, chain0_nxt};
    res.frame_sent  = sent;
    res.test_led    = test_nxt;
    res.key_value   = key;
    res.key_valid   = valid;
    res.buzzer_left = buzz_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain1_r   <= '0;
      chain0_r   <= '0;
      buzz_cnt_r <= '0;
      col_r      <= '0;
      acc_r      <= '0;
      test_r     <= 1'b0;
    end else if (op_pop) begin
      chain1_r   <= chain1_nxt;
      chain0_r   <= chain0_nxt;
      buzz_cnt_r <= buzz_cnt_nxt;
      col_r      <= col_nxt;
      acc_r      <= acc_nxt;
      test_r     <= test_nxt;
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < sckl_pkg::COL_W'(sckl_pkg::SCAN_COLUMNS))
    else $error("scan column out of range");

  a_key_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.key_valid) |-> !res.frame_sent)
    else $error("completed scan also sent a frame");

  a_buzz_expire: assert property (@(posedge clk) disable iff (!rst_n)
    (op_pop && op.code == sckl_pkg::OP_TICK && buzz_cnt_r == 16'd1)
      |=> (buzz_cnt_r == '0 && !chain1_r[sckl_pkg::BIT_BUZZ]))
    else $error("buzzer did not switch off at count expiry");

endmodule

`default_nettype wire

### rtl/shift_chain_keypad_led_buzzer.sv
// An accepted item is written into the operation queue; the back end pops it when the
// result queue has room and writes its result there, for the out_ ports.
// Throughput: one item per cycle while the result queue has room; the back end updates
// the latch image, buzzer counter and scan state, with short queues on both sides.
// Reset (rst_n low, synchronous) clears the latch image, buzzer count, scan
// column, key accumulator, test LED and both queues.
`timescale 1ns / 1ps
`default_nettype none

module shift_chain_keypad_led_buzzer #(
  parameter int unsigned OP_DEPTH  = sckl_pkg::OP_QUEUE_DEPTH,
  parameter int unsigned OUT_DEPTH = sckl_pkg::OUT_QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire sckl_pkg::in_item_t  in_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output sckl_pkg::out_item_t      out_item
);

  localparam int unsigned OP_W  = $bits(sckl_pkg::op_t);
  localparam int unsigned RES_W = $bits(sckl_pkg::out_item_t);

  sckl_pkg::op_t       front_op, back_op;
  sckl_pkg::out_item_t back_res;
  logic                op_push, op_full, op_empty, op_pop;
  logic                res_push, res_full;
  logic [OP_W-1:0]     op_rdata;
  logic [RES_W-1:0]    res_rdata;

  // Front: accept and classify.
  sckl_front u_front (
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .op_push (op_push),
    .op_full (op_full),
    .op      (front_op)
  );

  // Operation queue between front and back.
  sckl_fifo #(
    .DEPTH (OP_DEPTH),
    .WIDTH (OP_W)
  ) u_op_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (op_push),
    .full  (op_full),
    .wdata (front_op),
    .pop   (op_pop),
    .empty (op_empty),
    .rdata (op_rdata)
  );

  assign back_op = sckl_pkg::op_t'(op_rdata);

  // Back: execute against the stored state.
  sckl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_empty (op_empty),
    .op       (back_op),
    .op_pop   (op_pop),
    .res_push (res_push),
    .res_full (res_full),
    .res      (back_res)
  );

  // Result queue toward the consumer.
  sckl_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH (RES_W)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .wdata (back_res),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (res_rdata)
  );

  assign out_item = sckl_pkg::out_item_t'(res_rdata);

endmodule

`default_nettype wire
